### src/lcr_pkg.sv
// Shared types, sizes and helper functions for the line clipper.
// Used by lcr_interp, line_clip_for_rasterizer_top and lcr_checker.
`timescale 1ns / 1ps
`default_nettype none

package lcr_pkg;

  localparam int W          = 32;
  localparam int DIV_STEPS  = 2;
  localparam int DIV_STAGES = W / DIV_STEPS;
  localparam int IP_DEPTH   = DIV_STAGES + 4;
  localparam int NPTS       = 4;

  typedef enum logic [2:0] {
    REG_LEFT   = 3'd0,
    REG_TOP    = 3'd1,
    REG_RIGHT  = 3'd2,
    REG_BOTTOM = 3'd3,
    REG_CULL   = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic              drop;
    logic              dir;
    logic              sel;
    logic              fa;
    logic              fb;
    logic signed [W-1:0] x0;
    logic signed [W-1:0] y0;
    logic signed [W-1:0] x1;
    logic signed [W-1:0] y1;
  } ctx_t;

  typedef struct packed {
    logic signed [W-1:0] p0;
    logic signed [W-1:0] p1;
    logic signed [W:0]   num;
    logic signed [W:0]   dp;
    logic signed [W:0]   den;
  } rlane_t;

  typedef struct packed {
    logic signed [W-1:0] p0;
    logic signed [W-1:0] half;
    logic                neg;
    logic                dz;
    logic [W-1:0]        anum;
    logic [W-1:0]        adp;
    logic [W-1:0]        aden;
  } lane_t;

  typedef struct packed {
    logic signed [W-1:0] p0;
    logic signed [W-1:0] half;
    logic                neg;
    logic                dz;
    logic                sat;
    logic [W-1:0]        adp;
    logic [W-1:0]        aden;
    logic [W-1:0]        r;
    logic [W-1:0]        nb;
    logic [W-1:0]        q;
  } dlane_t;

  function automatic logic signed [W:0] wide(logic signed [W-1:0] a);
    return {a[W-1], a};
  endfunction

  function automatic logic [W-1:0] magnitude(logic signed [W:0] v);
    logic [W:0] t;
    t = v[W] ? (~v + 1'b1) : v;
    return t[W-1:0];
  endfunction

  // Restoring division, DIV_STEPS quotient bits.
  function automatic dlane_t div_stage(dlane_t s);
    dlane_t     o;
    logic [W:0] t;
    o = s;
    for (int k = 0; k < DIV_STEPS; k++) begin
      t    = {o.r, o.nb[W-1]};
      o.nb = o.nb << 1;
      if (t >= {1'b0, o.aden}) begin
        o.r = W'(t - {1'b0, o.aden});
        o.q = {o.q[W-2:0], 1'b1};
      end else begin
        o.r = t[W-1:0];
        o.q = {o.q[W-2:0], 1'b0};
      end
    end
    return o;
  endfunction

endpackage

`default_nettype wire

### src/lcr_interp.sv
// Two-lane pipelined interpolation unit: multiply, divide and offset.
// Depends on lcr_pkg; carries an item's context alongside the lanes.
`timescale 1ns / 1ps
`default_nettype none

module lcr_interp (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  lcr_pkg::ctx_t              ctx_i,
  input  lcr_pkg::rlane_t            lane_i [2],
  output logic                       valid_o,
  output lcr_pkg::ctx_t              ctx_o,
  output logic signed [lcr_pkg::W-1:0] res_o [2]
);
  import lcr_pkg::*;

  logic [IP_DEPTH-1:0] v_q;
  ctx_t                ctx_q [IP_DEPTH];
  rlane_t              rl_q  [2];
  lane_t               ln_q  [2];
  lane_t               ln_d  [2];
  dlane_t              dv_q  [2][DIV_STAGES+1];
  dlane_t              mul_d [2];
  logic signed [W-1:0] res_q [2];
  logic signed [W-1:0] res_d [2];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      logic signed [W:0] sum;
      dlane_t            d;
      logic [W-1:0]      m;
      logic [2*W-1:0]    prod;
      sum          = wide(rl_q[l].p0) + wide(rl_q[l].p1);
      ln_d[l].p0   = rl_q[l].p0;
      ln_d[l].half = sum[W:1];
      ln_d[l].neg  = rl_q[l].num[W] ^ rl_q[l].dp[W] ^ rl_q[l].den[W];
      ln_d[l].dz   = (rl_q[l].den == '0);
      ln_d[l].anum = magnitude(rl_q[l].num);
      ln_d[l].adp  = magnitude(rl_q[l].dp);
      ln_d[l].aden = magnitude(rl_q[l].den);

      prod          = ln_q[l].anum * ln_q[l].adp;
      mul_d[l].p0   = ln_q[l].p0;
      mul_d[l].half = ln_q[l].half;
      mul_d[l].neg  = ln_q[l].neg;
      mul_d[l].dz   = ln_q[l].dz;
      mul_d[l].sat  = (ln_q[l].anum >= ln_q[l].aden);
      mul_d[l].adp  = ln_q[l].adp;
      mul_d[l].aden = ln_q[l].aden;
      mul_d[l].r    = prod[2*W-1:W];
      mul_d[l].nb   = prod[W-1:0];
      mul_d[l].q    = '0;

      d = dv_q[l][DIV_STAGES];
      m = d.sat ? d.adp : d.q;
      if (d.dz) begin
        res_d[l] = d.half;
      end else if (d.neg) begin
        res_d[l] = d.p0 - $signed(m);
      end else begin
        res_d[l] = d.p0 + $signed(m);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[IP_DEPTH-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctx_q[0] <= ctx_i;
      for (int k = 1; k < IP_DEPTH; k++) begin
        ctx_q[k] <= ctx_q[k-1];
      end
      for (int l = 0; l < 2; l++) begin
        rl_q[l]     <= lane_i[l];
        ln_q[l]     <= ln_d[l];
        dv_q[l][0]  <= mul_d[l];
        for (int s = 0; s < DIV_STAGES; s++) begin
          dv_q[l][s+1] <= div_stage(dv_q[l][s]);
        end
        res_q[l]    <= res_d[l];
      end
    end
  end

  assign valid_o  = v_q[IP_DEPTH-1];
  assign ctx_o    = ctx_q[IP_DEPTH-1];
  assign res_o[0] = res_q[0];
  assign res_o[1] = res_q[1];

endmodule

`default_nettype wire

### src/line_clip_for_rasterizer_top.sv
// An accepted item passes the input registers, the y interpolator, t_q, the x
// interpolator and the output buffer; its points then leave on consecutive
// cycles when not stalled. A segment may enter every cycle while in_stall_o is
// low; the result channel emits 2 to 4 points per kept segment, none for a
// dropped one, one point per cycle when not stalled. Reset clears all valid
// bits, the output buffer's control state and the configuration registers (all zero).
`timescale 1ns / 1ps
`default_nettype none

module line_clip_for_rasterizer_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [2:0]                    cfg_idx_i,
  input  logic [lcr_pkg::W-1:0]         cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [lcr_pkg::W-1:0]  start_x_i,
  input  logic signed [lcr_pkg::W-1:0]  start_y_i,
  input  logic signed [lcr_pkg::W-1:0]  end_x_i,
  input  logic signed [lcr_pkg::W-1:0]  end_y_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [lcr_pkg::W-1:0]  point_x_o,
  output logic signed [lcr_pkg::W-1:0]  point_y_o,
  output logic                          last_point_o
);
  import lcr_pkg::*;

  logic signed [W-1:0] left_q, top_q, right_q, bottom_q;
  logic                cull_q;

  logic                in_v_q;
  logic signed [W-1:0] sx_q, sy_q, ex_q, ey_q;
  logic                en;

  ctx_t                ctx1_d, m1_ctx, t_d, t_q, ctx2_d, m2_ctx;
  rlane_t              rl1_d [2];
  rlane_t              rl2_d [2];
  logic                m1_v, m2_v, tv_q;
  logic signed [W-1:0] m1_res [2];
  logic signed [W-1:0] m2_res [2];

  logic                busy_q, rev_q;
  logic [1:0]          idx_q, last_q, rd_idx;
  logic signed [W-1:0] ptx_q [NPTS];
  logic signed [W-1:0] pty_q [NPTS];
  logic signed [W-1:0] ptx_d [NPTS];
  logic signed [W-1:0] pty_d [NPTS];
  logic [1:0]          ld_last;
  logic                ld_rev, ob_fire, ob_done, ob_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q   <= '0;
      top_q    <= '0;
      right_q  <= '0;
      bottom_q <= '0;
      cull_q   <= 1'b0;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_LEFT:   left_q   <= cfg_data_i;
        REG_TOP:    top_q    <= cfg_data_i;
        REG_RIGHT:  right_q  <= cfg_data_i;
        REG_BOTTOM: bottom_q <= cfg_data_i;
        REG_CULL:   cull_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign ob_fire = busy_q && !out_stall_i;
  assign ob_done = ob_fire && (idx_q == last_q);
  assign en      = !busy_q || ob_done || !m2_v;
  assign ob_load = en && m2_v && !m2_ctx.drop;
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
      tv_q   <= 1'b0;
    end else if (en) begin
      in_v_q <= in_valid_i;
      tv_q   <= m1_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sx_q <= start_x_i;
      sy_q <= start_y_i;
      ex_q <= end_x_i;
      ey_q <= end_y_i;
      t_q  <= t_d;
    end
  end

  always_comb begin
    logic                ylo;
    logic signed [W-1:0] pyl, pyh;
    ylo         = !(sy_q < ey_q);
    pyl         = ylo ? ey_q : sy_q;
    pyh         = ylo ? sy_q : ey_q;
    ctx1_d.drop = (pyh <= top_q) || (pyl >= bottom_q);
    ctx1_d.dir  = !(sx_q < ex_q);
    ctx1_d.sel  = ylo;
    ctx1_d.fa   = pyl < top_q;
    ctx1_d.fb   = pyh > bottom_q;
    ctx1_d.x0   = sx_q;
    ctx1_d.y0   = sy_q;
    ctx1_d.x1   = ex_q;
    ctx1_d.y1   = ey_q;
    for (int l = 0; l < 2; l++) begin
      rl1_d[l].p0  = sx_q;
      rl1_d[l].p1  = ex_q;
      rl1_d[l].dp  = wide(ex_q) - wide(sx_q);
      rl1_d[l].den = wide(ey_q) - wide(sy_q);
    end
    rl1_d[0].num = wide(top_q) - wide(sy_q);
    rl1_d[1].num = wide(bottom_q) - wide(sy_q);
  end

  lcr_interp u_ip_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_v_q),
    .ctx_i   (ctx1_d),
    .lane_i  (rl1_d),
    .valid_o (m1_v),
    .ctx_o   (m1_ctx),
    .res_o   (m1_res)
  );

  always_comb begin
    t_d = m1_ctx;
    if (m1_ctx.fa) begin
      if (m1_ctx.sel) begin
        t_d.x1 = m1_res[0];
        t_d.y1 = top_q;
      end else begin
        t_d.x0 = m1_res[0];
        t_d.y0 = top_q;
      end
    end
    if (m1_ctx.fb) begin
      if (m1_ctx.sel) begin
        t_d.x0 = m1_res[1];
        t_d.y0 = bottom_q;
      end else begin
        t_d.x1 = m1_res[1];
        t_d.y1 = bottom_q;
      end
    end
  end

  always_comb begin
    logic signed [W-1:0] txa, txb;
    logic                pinned;
    txa         = t_q.dir ? t_q.x1 : t_q.x0;
    txb         = t_q.dir ? t_q.x0 : t_q.x1;
    pinned      = (txb <= left_q) || (txa >= right_q);
    ctx2_d      = t_q;
    ctx2_d.drop = t_q.drop || (pinned && (txb > left_q) && cull_q);
    ctx2_d.sel  = pinned;
    ctx2_d.fa   = txa < left_q;
    ctx2_d.fb   = txb > right_q;
    for (int l = 0; l < 2; l++) begin
      rl2_d[l].p0  = t_q.y0;
      rl2_d[l].p1  = t_q.y1;
      rl2_d[l].dp  = wide(t_q.y1) - wide(t_q.y0);
      rl2_d[l].den = wide(t_q.x1) - wide(t_q.x0);
    end
    rl2_d[0].num = wide(left_q) - wide(t_q.x0);
    rl2_d[1].num = wide(right_q) - wide(t_q.x0);
  end

  lcr_interp u_ip_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (tv_q),
    .ctx_i   (ctx2_d),
    .lane_i  (rl2_d),
    .valid_o (m2_v),
    .ctx_o   (m2_ctx),
    .res_o   (m2_res)
  );

  always_comb begin
    logic signed [W-1:0] txa, txb, tya, tyb, ylo, yhi, pl, pr, edge_x;
    txa = m2_ctx.dir ? m2_ctx.x1 : m2_ctx.x0;
    txb = m2_ctx.dir ? m2_ctx.x0 : m2_ctx.x1;
    tya = m2_ctx.dir ? m2_ctx.y1 : m2_ctx.y0;
    tyb = m2_ctx.dir ? m2_ctx.y0 : m2_ctx.y1;
    ylo = (tya < tyb) ? tya : tyb;
    yhi = (tya < tyb) ? tyb : tya;
    pl  = (m2_res[0] < ylo) ? ylo : ((m2_res[0] > yhi) ? yhi : m2_res[0]);
    pr  = (m2_res[1] < ylo) ? ylo : ((m2_res[1] > yhi) ? yhi : m2_res[1]);
    edge_x = (txb <= left_q) ? left_q : right_q;
    ptx_d[3] = right_q;
    pty_d[3] = tyb;
    if (m2_ctx.sel) begin
      ptx_d[0] = edge_x;
      pty_d[0] = m2_ctx.y0;
      ptx_d[1] = edge_x;
      pty_d[1] = m2_ctx.y1;
      ptx_d[2] = right_q;
      pty_d[2] = tyb;
      ld_last  = 2'd1;
      ld_rev   = 1'b0;
    end else begin
      ptx_d[0] = m2_ctx.fa ? left_q : txa;
      pty_d[0] = tya;
      if (m2_ctx.fa) begin
        ptx_d[1] = left_q;
        pty_d[1] = pl;
        ptx_d[2] = m2_ctx.fb ? right_q : txb;
        pty_d[2] = m2_ctx.fb ? pr : tyb;
      end else begin
        ptx_d[1] = m2_ctx.fb ? right_q : txb;
        pty_d[1] = m2_ctx.fb ? pr : tyb;
        ptx_d[2] = right_q;
        pty_d[2] = tyb;
      end
      ld_last = 2'd1 + {1'b0, m2_ctx.fa} + {1'b0, m2_ctx.fb};
      ld_rev  = m2_ctx.dir;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
      last_q <= '0;
      rev_q  <= 1'b0;
    end else if (ob_load) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
      last_q <= ld_last;
      rev_q  <= ld_rev;
    end else if (ob_done) begin
      busy_q <= 1'b0;
    end else if (ob_fire) begin
      idx_q <= idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ob_load) begin
      for (int k = 0; k < NPTS; k++) begin
        ptx_q[k] <= ptx_d[k];
        pty_q[k] <= pty_d[k];
      end
    end
  end

  assign rd_idx       = rev_q ? (last_q - idx_q) : idx_q;
  assign out_valid_o  = busy_q;
  assign point_x_o    = ptx_q[rd_idx];
  assign point_y_o    = pty_q[rd_idx];
  assign last_point_o = (idx_q == last_q);

endmodule

`default_nettype wire

### src/lcr_checker.sv
// Port-level checks on the clipper's result channel, bound to the top level.
// Depends on the top level's ports and on lcr_pkg for the width.
`timescale 1ns / 1ps
`default_nettype none

module lcr_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic signed [lcr_pkg::W-1:0] point_x_o,
  input logic signed [lcr_pkg::W-1:0] point_y_o,
  input logic                         last_point_o
);

  logic       acc;
  logic [1:0] cnt_q;

  assign acc = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (acc) begin
      cnt_q <= last_point_o ? 2'd0 : cnt_q + 2'd1;
    end
  end

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result valid dropped while stalled");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      $stable(point_x_o) && $stable(point_y_o) && $stable(last_point_o))
    else $error("result changed while stalled");

  a_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && !last_point_o |=> out_valid_o)
    else $error("gap inside one item's points");

  a_min_two: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && last_point_o |-> cnt_q != 2'd0)
    else $error("item with a single point");

  a_max_four: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && !last_point_o |-> cnt_q != 2'd3)
    else $error("item with more than four points");

endmodule

bind line_clip_for_rasterizer_top lcr_checker u_lcr_checker (.*);

`default_nettype wire
